[sv/boot_slot_rollback_decider_macros.svh]
// Assertion macros used by the boot slot rollback decider checker.
`ifndef BOOT_SLOT_ROLLBACK_DECIDER_MACROS_SVH
`define BOOT_SLOT_ROLLBACK_DECIDER_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define BSRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define BSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bsrd_pkg.sv]
// Types and constants for the boot slot rollback decider.
`timescale 1ns / 1ps
`default_nettype none

package bsrd_pkg;

    // Trailer record states as stored in flash; codes above unknown act as unknown
    localparam logic [2:0] TST_NONE      = 3'd0;
    localparam logic [2:0] TST_PENDING   = 3'd1;
    localparam logic [2:0] TST_CONFIRMED = 3'd2;
    localparam logic [2:0] TST_REJECTED  = 3'd3;

    // State written into a new trailer record
    localparam logic WST_PENDING  = 1'b0;
    localparam logic WST_REJECTED = 1'b1;

    // Trailer slot select
    localparam logic SLOT_ACTIVE   = 1'b0;
    localparam logic SLOT_INACTIVE = 1'b1;

    // Register map
    localparam logic REG_TRIAL_LIMIT = 1'b0;
    localparam logic [7:0] TRIAL_LIMIT_RST = 8'd3;
    localparam logic [7:0] ATTEMPT_MAX     = 8'hFF;

    typedef enum logic [2:0] {
        ACT_BOOT     = 3'd0,
        ACT_CONTINUE = 3'd1,
        ACT_SWAP_NEW = 3'd2,
        ACT_SWAP_OLD = 3'd3,
        ACT_DFU      = 3'd4
    } t_action;

    typedef struct packed {
        logic        active_valid;
        logic        inactive_valid;
        logic [23:0] active_version;
        logic [23:0] inactive_version;
        logic [31:0] active_image_crc;
        logic [31:0] inactive_image_crc;
        logic [2:0]  active_trailer_state;
        logic [7:0]  active_trailer_attempt;
        logic [31:0] active_trailer_crc;
        logic [2:0]  inactive_trailer_state;
        logic [31:0] inactive_trailer_crc;
    } t_in_word;

    typedef struct packed {
        t_action     boot_action;
        logic        write_valid;
        logic        write_slot;
        logic        write_state;
        logic [7:0]  write_attempt;
        logic [31:0] write_crc;
        logic        last_result;
    } t_out_word;

    // One trailer write request
    typedef struct packed {
        logic        slot;
        logic        state;
        logic [7:0]  attempt;
        logic [31:0] crc;
    } t_wr_rec;

    // Decision for one request: action and up to two writes
    typedef struct packed {
        t_action     action;
        logic [1:0]  wr_cnt;
        t_wr_rec     wr0;
        t_wr_rec     wr1;
    } t_decision;

endpackage

`default_nettype wire

[sv/boot_slot_rollback_decider.sv]
// Top level of the boot slot rollback decider.
//
//  channel   direction  handshake                        word
//  request   in         i_in_valid / o_in_ready          t_in_word
//  result    out        o_out_valid / i_out_ready        t_out_word
//  config    in         psel, penable, pwrite, pready    trial limit at byte 0
//
// A request passes an input register and then a result register, which offers
// its first word; one request can enter per cycle while the result side is not stalled.
// A request with two trailer writes holds the result register for two words,
// so the next request waits in the input register until the second word leaves.
// Synchronous active-low reset empties both registers and sets the trial limit to 3.
// A stalled result keeps accepting one more request into the input register.
`timescale 1ns / 1ps
`default_nettype none

module boot_slot_rollback_decider
    import bsrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_in_valid;
    t_in_word   r_in;
    logic [7:0] r_trial_limit;
    t_decision  dec;
    logic       dec_ready;
    logic       cfg_wr;

    // Config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TRIAL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trial_limit <= TRIAL_LIMIT_RST;
        end else if (cfg_wr) begin
            r_trial_limit <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_TRIAL_LIMIT) ? {24'd0, r_trial_limit} : 32'd0;

    // Input register: refill when empty or when its word moves on
    assign o_in_ready = !r_in_valid || dec_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    bsrd_decide u_decide (
        .i_in          (r_in),
        .i_trial_limit (r_trial_limit),
        .o_dec         (dec)
    );

    bsrd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dec_valid (r_in_valid),
        .i_dec       (dec),
        .o_dec_ready (dec_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[sv/bsrd_decide.sv]
// Combinational boot decision for one request word.
`timescale 1ns / 1ps
`default_nettype none

module bsrd_decide
    import bsrd_pkg::*;
(
    input  t_in_word   i_in,
    input  logic [7:0] i_trial_limit,
    output t_decision  o_dec
);

    logic    a_bound;
    logic    i_bound;
    logic    i_rejected;
    logic    i_unusable;
    logic    upgrade_ok;
    logic [7:0] incr_attempt;
    t_wr_rec rec_rej_active;
    t_wr_rec rec_new_active;
    t_wr_rec rec_new_inactive;
    t_wr_rec rec_incr_active;

    // Bind trailers to images by CRC
    assign a_bound = (i_in.active_trailer_state != TST_NONE) && i_in.active_valid
                     && (i_in.active_trailer_crc == i_in.active_image_crc);
    assign i_bound = (i_in.inactive_trailer_state != TST_NONE) && i_in.inactive_valid
                     && (i_in.inactive_trailer_crc == i_in.inactive_image_crc);
    assign i_rejected = i_bound && (i_in.inactive_trailer_state == TST_REJECTED);
    assign i_unusable = !i_in.inactive_valid || i_rejected;

    // Newer inactive image that is neither rejected nor confirmed
    assign upgrade_ok = i_in.inactive_valid
                        && (i_in.inactive_version > i_in.active_version)
                        && !(i_bound && ((i_in.inactive_trailer_state == TST_REJECTED)
                                      || (i_in.inactive_trailer_state == TST_CONFIRMED)));

    // Saturating attempt increment
    assign incr_attempt = (i_in.active_trailer_attempt == ATTEMPT_MAX) ? ATTEMPT_MAX
                          : i_in.active_trailer_attempt + 8'd1;

    // Candidate records
    assign rec_rej_active   = '{slot: SLOT_ACTIVE, state: WST_REJECTED, attempt: 8'd0,
                                crc: i_in.active_image_crc};
    assign rec_new_active   = '{slot: SLOT_ACTIVE, state: WST_PENDING, attempt: 8'd1,
                                crc: i_in.active_image_crc};
    assign rec_new_inactive = '{slot: SLOT_INACTIVE, state: WST_PENDING, attempt: 8'd1,
                                crc: i_in.inactive_image_crc};
    assign rec_incr_active  = '{slot: SLOT_ACTIVE, state: WST_PENDING, attempt: incr_attempt,
                                crc: i_in.active_trailer_crc};

    // Pick the action and the writes
    always_comb begin
        o_dec.action = ACT_BOOT;
        o_dec.wr_cnt = 2'd0;
        o_dec.wr0    = rec_new_inactive;
        o_dec.wr1    = rec_new_inactive;
        if (!i_in.active_valid ||
            (a_bound && (i_in.active_trailer_state == TST_REJECTED))) begin
            // Fall back to the other image
            if (i_unusable) begin
                o_dec.action = ACT_DFU;
            end else begin
                o_dec.action = ACT_SWAP_OLD;
                o_dec.wr_cnt = i_bound ? 2'd0 : 2'd1;
            end
        end else if (!a_bound) begin
            // Start a trial of the unbound active image
            o_dec.action = ACT_CONTINUE;
            o_dec.wr_cnt = 2'd1;
            o_dec.wr0    = rec_new_active;
        end else if (i_in.active_trailer_state == TST_PENDING) begin
            if (i_in.active_trailer_attempt >= i_trial_limit) begin
                // Trials used up: reject and revert
                o_dec.wr0 = rec_rej_active;
                if (i_unusable) begin
                    o_dec.action = ACT_DFU;
                    o_dec.wr_cnt = 2'd1;
                end else begin
                    o_dec.action = ACT_SWAP_OLD;
                    o_dec.wr_cnt = i_bound ? 2'd1 : 2'd2;
                end
            end else begin
                o_dec.action = ACT_CONTINUE;
                o_dec.wr_cnt = 2'd1;
                o_dec.wr0    = rec_incr_active;
            end
        end else if (upgrade_ok) begin
            // Confirmed or unknown active image: take the upgrade
            o_dec.action = ACT_SWAP_NEW;
            o_dec.wr_cnt = (i_bound && (i_in.inactive_trailer_state == TST_PENDING))
                           ? 2'd0 : 2'd1;
        end
    end

endmodule

`default_nettype wire

[sv/bsrd_out_stage.sv]
// Result register that splits a decision into one or two result words.
`timescale 1ns / 1ps
`default_nettype none

module bsrd_out_stage
    import bsrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_dec_valid,
    input  t_decision i_dec,
    output logic      o_dec_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic      r_valid;
    logic      r_second_valid;
    t_out_word r_word;
    t_out_word r_second;
    t_out_word first_word;
    t_out_word second_word;
    logic      take;
    logic      pop;

    // Build the words of the incoming decision
    always_comb begin
        first_word.boot_action = i_dec.action;
        first_word.write_valid = (i_dec.wr_cnt != 2'd0);
        if (i_dec.wr_cnt != 2'd0) begin
            first_word.write_slot    = i_dec.wr0.slot;
            first_word.write_state   = i_dec.wr0.state;
            first_word.write_attempt = i_dec.wr0.attempt;
            first_word.write_crc     = i_dec.wr0.crc;
        end else begin
            first_word.write_slot    = 1'b0;
            first_word.write_state   = 1'b0;
            first_word.write_attempt = 8'd0;
            first_word.write_crc     = 32'd0;
        end
        first_word.last_result = (i_dec.wr_cnt != 2'd2);

        second_word.boot_action   = i_dec.action;
        second_word.write_valid   = 1'b1;
        second_word.write_slot    = i_dec.wr1.slot;
        second_word.write_state   = i_dec.wr1.state;
        second_word.write_attempt = i_dec.wr1.attempt;
        second_word.write_crc     = i_dec.wr1.crc;
        second_word.last_result   = 1'b1;
    end

    // Take a decision when empty or when the last word leaves
    assign pop         = r_valid && i_out_ready;
    assign o_dec_ready = !r_valid || (i_out_ready && !r_second_valid);
    assign take        = i_dec_valid && o_dec_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_second_valid <= 1'b0;
        end else if (take) begin
            r_valid        <= 1'b1;
            r_second_valid <= (i_dec.wr_cnt == 2'd2);
        end else if (pop) begin
            r_valid        <= r_second_valid;
            r_second_valid <= 1'b0;
        end
    end

    // Load or advance the payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word   <= first_word;
            r_second <= second_word;
        end else if (pop && r_second_valid) begin
            r_word <= r_second;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;

endmodule

`default_nettype wire

[sv/bsrd_checker.sv]
// Port-level checks on the result channel of the boot slot rollback decider.
`timescale 1ns / 1ps
`default_nettype none

`include "boot_slot_rollback_decider_macros.svh"

module bsrd_checker
    import bsrd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // A stalled result word holds
    `BSRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result word changed while stalled")

    // A word without a write is the only word of its request and carries zeros
    `BSRD_ASSERT_NOW(a_no_write_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.write_valid, o_out_data.last_result && !o_out_data.write_slot && !o_out_data.write_state && (o_out_data.write_attempt == 8'd0) && (o_out_data.write_crc == 32'd0), "write-free word is not a clean single word")

    // The first of two writes rejects the active slot
    `BSRD_ASSERT_NOW(a_first_of_two, i_clk, i_rst_n, o_out_valid && !o_out_data.last_result, o_out_data.write_valid && (o_out_data.write_slot == SLOT_ACTIVE) && (o_out_data.write_state == WST_REJECTED) && (o_out_data.boot_action == ACT_SWAP_OLD), "bad first word of a double write")

    // The second write follows at once with the same action
    `BSRD_ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_data.last_result, o_out_valid && o_out_data.last_result && (o_out_data.write_slot == SLOT_INACTIVE) && (o_out_data.boot_action == $past(o_out_data.boot_action)), "second write word missing or wrong")

endmodule

bind boot_slot_rollback_decider bsrd_checker u_bsrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[tb/bsrd_decision_checker.sv]
// Decision checker for the boot slot rollback decider: predicts each request's words and compares them.
`timescale 1ns / 1ps

module bsrd_decision_checker
    import bsrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_in_word    i_req_word,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  t_out_word   i_res_word,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_words_owed
);

    localparam int         REPORT_CAP       = 100;
    localparam logic [2:0] TRIAL_LIMIT_ADDR = {REG_TRIAL_LIMIT, 2'b00};

    logic [7:0] attempt_limit;
    t_out_word  owed_words [$];
    int         reported;

    initial begin
        attempt_limit = TRIAL_LIMIT_RST;
        o_fail_count  = 0;
        o_words_owed  = 0;
        reported      = 0;
    end

    // Build one trailer write word; action and last flag are stamped later
    function automatic t_out_word trailer_write(input logic slot, input logic state,
                                                input logic [7:0] attempt,
                                                input logic [31:0] crc);
        t_out_word w;
        w               = '0;
        w.write_valid   = 1'b1;
        w.write_slot    = slot;
        w.write_state   = state;
        w.write_attempt = attempt;
        w.write_crc     = crc;
        return w;
    endfunction

    // Decide one boot request and queue the words it must produce
    function automatic void predict_decision(input t_in_word q);
        logic      act_bound;
        logic      ina_bound;
        logic      ina_refused;
        logic      revert;
        t_action   act;
        t_out_word words [$];
        t_out_word w;

        act_bound   = q.active_trailer_state != TST_NONE && q.active_valid
                      && q.active_trailer_crc == q.active_image_crc;
        ina_bound   = q.inactive_trailer_state != TST_NONE && q.inactive_valid
                      && q.inactive_trailer_crc == q.inactive_image_crc;
        ina_refused = ina_bound && q.inactive_trailer_state == TST_REJECTED;
        revert      = 1'b0;
        act         = ACT_BOOT;

        if (!q.active_valid) begin
            revert = 1'b1;
        end else if (!act_bound) begin
            // unbound active image starts a fresh trial
            words.push_back(trailer_write(SLOT_ACTIVE, WST_PENDING, 8'd1, q.active_image_crc));
            act = ACT_CONTINUE;
        end else if (q.active_trailer_state == TST_PENDING) begin
            if (q.active_trailer_attempt >= attempt_limit) begin
                // out of trials: reject and fall back
                words.push_back(trailer_write(SLOT_ACTIVE, WST_REJECTED, 8'd0,
                                              q.active_image_crc));
                revert = 1'b1;
            end else begin
                words.push_back(trailer_write(SLOT_ACTIVE, WST_PENDING,
                    (q.active_trailer_attempt == ATTEMPT_MAX) ? ATTEMPT_MAX
                                                              : q.active_trailer_attempt + 8'd1,
                    q.active_trailer_crc));
                act = ACT_CONTINUE;
            end
        end else if (q.active_trailer_state == TST_REJECTED) begin
            revert = 1'b1;
        end else if (q.inactive_valid && q.inactive_version > q.active_version
                     && !(ina_bound && (q.inactive_trailer_state == TST_REJECTED
                                        || q.inactive_trailer_state == TST_CONFIRMED))) begin
            // newer image in the other slot: take it as an upgrade
            if (!(ina_bound && q.inactive_trailer_state == TST_PENDING))
                words.push_back(trailer_write(SLOT_INACTIVE, WST_PENDING, 8'd1,
                                              q.inactive_image_crc));
            act = ACT_SWAP_NEW;
        end

        // Fall back to the other slot, or to DFU when it is unusable
        if (revert) begin
            if (!q.inactive_valid || ina_refused) begin
                act = ACT_DFU;
            end else begin
                if (!ina_bound)
                    words.push_back(trailer_write(SLOT_INACTIVE, WST_PENDING, 8'd1,
                                                  q.inactive_image_crc));
                act = ACT_SWAP_OLD;
            end
        end

        if (words.size() == 0)
            words.push_back('0);
        foreach (words[k]) begin
            w             = words[k];
            w.boot_action = act;
            w.last_result = (k == words.size() - 1);
            owed_words.push_back(w);
        end
    endfunction

    // Flag one field that differs from its prediction
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (reported < REPORT_CAP)
                $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            reported++;
        end
    endtask

    // Track the register, queue predictions and compare result words
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            attempt_limit = TRIAL_LIMIT_RST;
            owed_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == TRIAL_LIMIT_ADDR)
                attempt_limit = i_pwdata[7:0];
            if (i_req_valid && i_req_ready)
                predict_decision(i_req_word);
            if (i_res_valid && i_res_ready) begin
                if (owed_words.size() == 0) begin
                    o_fail_count++;
                    if (reported < REPORT_CAP)
                        $display("%0t ns: result word expected none, got %0h",
                                 $time, i_res_word);
                    reported++;
                end else begin
                    want = owed_words.pop_front();
                    check_field("boot_action", want.boot_action, i_res_word.boot_action);
                    check_field("write_valid", want.write_valid, i_res_word.write_valid);
                    check_field("write_slot", want.write_slot, i_res_word.write_slot);
                    check_field("write_state", want.write_state, i_res_word.write_state);
                    check_field("write_attempt", want.write_attempt, i_res_word.write_attempt);
                    check_field("write_crc", want.write_crc, i_res_word.write_crc);
                    check_field("last_result", want.last_result, i_res_word.last_result);
                end
            end
        end
        o_words_owed = owed_words.size();
    end

endmodule

[tb/tb_boot_slot_rollback_decider.sv]
// Testbench top for the boot slot rollback decider: reset, register writes, request stimulus, verdict.
`timescale 1ns / 1ps

module tb_boot_slot_rollback_decider;
    import bsrd_pkg::*;

    localparam logic [2:0] TST_UNKNOWN       = 3'd4;
    localparam logic [2:0] TST_TOP_CODE      = 3'd7;
    localparam logic [2:0] TRIAL_LIMIT_ADDR  = {REG_TRIAL_LIMIT, 2'b00};
    localparam int         DIRECTED_COUNT    = 25;
    localparam int         PHASE_COUNT       = 6;
    localparam int         RANDOM_PER_PHASE  = 292;
    localparam int         IDLE_PERCENT      = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        quiet_run;
    logic [7:0]  attempt_limit;
    int          fail_count;
    int          words_owed;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    boot_slot_rollback_decider u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bsrd_decision_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_in_valid),
        .i_req_ready  (o_in_ready),
        .i_req_word   (i_in_data),
        .i_res_valid  (o_out_valid),
        .i_res_ready  (i_out_ready),
        .i_res_word   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_words_owed (words_owed)
    );

    // Hard stop in case the block hangs
    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

    // Stall the result side at random, except during the quiet phase
    always @(negedge i_clk)
        i_out_ready <= quiet_run || ($urandom_range(99) >= IDLE_PERCENT);

    // Trailer state with most weight on the named states
    function automatic logic [2:0] pick_state();
        int r;
        r = $urandom_range(15);
        if (r < 3)
            return TST_NONE;
        else if (r < 7)
            return TST_PENDING;
        else if (r < 11)
            return TST_CONFIRMED;
        else if (r < 14)
            return TST_REJECTED;
        return 3'($urandom_range(TST_TOP_CODE, TST_UNKNOWN));
    endfunction

    // Random boot request, mostly with trailers bound to their images
    function automatic t_in_word random_request(input logic [7:0] limit);
        t_in_word w;
        int       t;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        // leave a tenth as pure noise
        if ($urandom_range(9) == 0)
            return w;
        w.active_valid   = $urandom_range(99) < 85;
        w.inactive_valid = $urandom_range(99) < 85;
        case ($urandom_range(3))
            0: w.inactive_version = w.active_version;
            1: w.inactive_version = w.active_version + 24'd1;
            2: w.inactive_version = w.active_version - 24'd1;
            default: ;
        endcase
        w.active_trailer_state   = pick_state();
        w.inactive_trailer_state = pick_state();
        if ($urandom_range(99) < 80)
            w.active_trailer_crc = w.active_image_crc;
        else if ($urandom_range(1))
            w.active_trailer_crc = w.active_image_crc ^ (32'd1 << $urandom_range(31));
        if ($urandom_range(99) < 80)
            w.inactive_trailer_crc = w.inactive_image_crc;
        else if ($urandom_range(1))
            w.inactive_trailer_crc = w.inactive_image_crc ^ (32'd1 << $urandom_range(31));
        // put half of the attempt counts right around the limit
        if ($urandom_range(1)) begin
            t = int'(limit) + int'($urandom_range(2)) - 1;
            if (t < 0)
                t = 0;
            if (t > 255)
                t = 255;
            w.active_trailer_attempt = 8'(t);
        end
        return w;
    endfunction

    // Hand-picked requests: every action, the double trailer write, field extremes
    function automatic t_in_word directed_request(input int k);
        t_in_word w;
        w.active_valid           = 1'b1;
        w.inactive_valid         = 1'b1;
        w.active_version         = 24'h010203;
        w.inactive_version       = 24'h010300;
        w.active_image_crc       = 32'h1234_5678;
        w.inactive_image_crc     = 32'h9abc_def0;
        w.active_trailer_state   = TST_CONFIRMED;
        w.active_trailer_attempt = 8'd0;
        w.active_trailer_crc     = 32'h1234_5678;
        w.inactive_trailer_state = TST_NONE;
        w.inactive_trailer_crc   = 32'h9abc_def0;
        case (k)
            0: begin
                w.active_valid   = 1'b0;
                w.inactive_valid = 1'b0;
            end
            1: w.active_valid = 1'b0;
            2: begin
                w.active_valid           = 1'b0;
                w.inactive_trailer_state = TST_PENDING;
            end
            3: begin
                w.active_valid           = 1'b0;
                w.inactive_trailer_state = TST_REJECTED;
            end
            4: w.active_trailer_state = TST_NONE;
            5: w.active_trailer_crc = ~w.active_image_crc;
            6: w.active_trailer_state = TST_PENDING;
            7: begin
                w.active_trailer_state   = TST_PENDING;
                w.active_trailer_attempt = 8'd2;
            end
            8: begin
                w.active_trailer_state   = TST_PENDING;
                w.active_trailer_attempt = 8'd3;
            end
            9: begin
                w.active_trailer_state   = TST_PENDING;
                w.active_trailer_attempt = 8'd255;
                w.inactive_valid         = 1'b0;
            end
            10: begin
                w.active_trailer_state   = TST_PENDING;
                w.active_trailer_attempt = 8'd3;
                w.inactive_trailer_state = TST_REJECTED;
            end
            11: begin
                w.active_trailer_state   = TST_PENDING;
                w.active_trailer_attempt = 8'd3;
                w.inactive_trailer_state = TST_CONFIRMED;
            end
            12: w.active_trailer_state = TST_REJECTED;
            13: begin
                w.active_trailer_state = TST_REJECTED;
                w.inactive_valid       = 1'b0;
            end
            14: ;
            15: w.inactive_trailer_state = TST_PENDING;
            16: w.inactive_trailer_state = TST_CONFIRMED;
            17: w.inactive_trailer_state = TST_REJECTED;
            18: w.inactive_version = 24'h010202;
            19: w.inactive_version = w.active_version;
            20: begin
                w.active_trailer_state   = TST_UNKNOWN;
                w.inactive_trailer_state = TST_TOP_CODE;
            end
            21: begin
                w.active_trailer_state = TST_TOP_CODE;
                w.active_version       = '0;
                w.inactive_version     = '1;
                w.active_image_crc     = '1;
                w.active_trailer_crc   = '1;
                w.inactive_image_crc   = '1;
                w.inactive_trailer_crc = '1;
            end
            22: begin
                w.active_version       = '1;
                w.inactive_version     = '0;
                w.active_image_crc     = '0;
                w.active_trailer_crc   = '0;
                w.inactive_image_crc   = '0;
                w.inactive_trailer_crc = '0;
            end
            23: w.inactive_valid = 1'b0;
            default: begin
                // rejected record that does not bind to the image
                w.active_valid           = 1'b0;
                w.inactive_trailer_state = TST_REJECTED;
                w.inactive_trailer_crc   = ~w.inactive_image_crc;
            end
        endcase
        return w;
    endfunction

    // Offer one request word, with a random gap first; returns on a falling edge
    task automatic send_request(input t_in_word w);
        if (!quiet_run)
            while ($urandom_range(99) < IDLE_PERCENT) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Register write: setup phase, then access phase until pready
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid and hold until every predicted word has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (words_owed != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        quiet_run     = 1'b0;
        attempt_limit = TRIAL_LIMIT_RST;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests under the reset limit
        for (int k = 0; k < DIRECTED_COUNT; k++)
            send_request(directed_request(k));
        wait_idle();

        // Random phases, each under its own attempt limit
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: attempt_limit = 8'd255;
                1: attempt_limit = 8'd1;
                2: attempt_limit = 8'd0;
                3: attempt_limit = 8'($urandom_range(254, 2));
                4: attempt_limit = 8'($urandom_range(255));
                default: attempt_limit = TRIAL_LIMIT_RST;
            endcase
            write_register(TRIAL_LIMIT_ADDR, {24'd0, attempt_limit});
            quiet_run <= (p == 1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request(attempt_limit));
            wait_idle();
        end

        // Let any stray word show up before the verdict
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && words_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[boot_slot_rollback_decider.f]
+incdir+sv
sv/bsrd_pkg.sv
sv/bsrd_decide.sv
sv/bsrd_out_stage.sv
sv/boot_slot_rollback_decider.sv
sv/bsrd_checker.sv
tb/bsrd_decision_checker.sv
tb/tb_boot_slot_rollback_decider.sv
